/* rtl/core/gpta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpta_pkg
// Shared types, constants and helpers for the genotype pair table
// accumulator: table geometry, command codes and the saturating arithmetic.
// ----------------------------------------------------------------------------
package gpta_pkg;

  localparam int POSITIONS            = 1024;
  localparam int ENTRIES_PER_POSITION = 32;
  localparam int SLOTS                = 4;
  localparam int IDX_W                = 3;
  localparam int POS_W                = $clog2(POSITIONS);
  localparam int BANK_DEPTH           = POSITIONS * (ENTRIES_PER_POSITION / SLOTS);
  localparam int BANK_AW              = $clog2(BANK_DEPTH);
  localparam int MISS_W               = 13;

  localparam logic             CMD_LOAD  = 1'b0;
  localparam logic             CMD_ACCUM = 1'b1;
  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

  typedef logic [BANK_AW-1:0]   bank_addr_t;
  typedef logic [31:0]          word_t;
  typedef logic signed [63:0]   sum_t;
  typedef logic signed [33:0]   part_t;   // sum of up to four table words

  typedef struct packed {
    logic       en;
    bank_addr_t addr;
    word_t      data;
  } bank_wr_t;

  // Index of a slot's entry within its 8-word group
  function automatic logic [IDX_W-1:0] slot_index(input logic [1:0] a, input logic [1:0] b);
    logic m;
    m = (a == 2'b11) || (b == 2'b11);
    return {a[1] | b[1], (a[1] & b[1]) | (a[0] & b[0]) | m, a[0] | b[0]};
  endfunction

  function automatic logic slot_missing(input logic [1:0] a, input logic [1:0] b);
    return (a == 2'b11) || (b == 2'b11);
  endfunction

  // Saturating add of a table word to a 64-bit bound
  function automatic sum_t clamp_add(input sum_t bnd, input logic signed [31:0] v);
    logic signed [64:0] s;
    s = 65'(bnd) + 65'(v);
    if (s[64] != s[63]) begin
      return s[64] ? SUM_MIN : SUM_MAX;
    end
    return s[63:0];
  endfunction

endpackage

/* rtl/core/genotype_pair_table_accumulate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genotype_pair_table_accumulate
// Looks up one table product per genotype slot of a byte pair and keeps a
// saturating Q48.16 sum and a missing-slot count over a run.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  command, table_address, table_value,
//                                         geno_a, geno_b, byte_position, last
//  out_     output     out_valid/out_stall missing_count, sum_value
//
//  One transaction per cycle while in_stall is low. The four slots read four
//  table banks in the cycle of acceptance; the result of a last item passes
//  through stages p1 to p4 and then into the output register. The sum update
//  (one add, two compares) is combinational and sets the rate.
//  Reset clears the running values and pipeline; the table holds no reset
//  value and needs no clearing. in_stall rises only while a final item sits
//  in the last stage and the output register is still held.
// ----------------------------------------------------------------------------
module genotype_pair_table_accumulate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [14:0]         in_table_address,
  input  logic signed [31:0]  in_table_value,
  input  logic [7:0]          in_geno_a,
  input  logic [7:0]          in_geno_b,
  input  logic [9:0]          in_byte_position,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [12:0]         out_missing_count,
  output logic signed [63:0]  out_sum_value
);
  import gpta_pkg::*;

  logic       adv;
  logic       accept;
  logic       accum;
  logic [2:0] miss_item;

  bank_wr_t   bank_wr   [SLOTS];
  bank_addr_t bank_rd   [SLOTS];
  word_t      bank_data [SLOTS];

  // pipeline registers
  logic       p1_valid_r, p2_valid_r, p3_valid_r, p4_valid_r;
  logic       p1_last_r,  p2_last_r,  p3_last_r,  p4_last_r;
  logic [2:0] p1_miss_r,  p2_miss_r,  p3_miss_r,  p4_miss_r;
  part_t      p2_c_r, p3_c_r, p4_c_r;
  sum_t       p2_lo_r, p2_hi_r, p3_lo_r, p3_hi_r, p4_lo_r, p4_hi_r;
  logic signed [31:0] p2_v2_r, p2_v3_r, p3_v3_r;

  sum_t        acc_r, acc_nxt;
  logic [12:0] cnt_r, cnt_nxt;
  logic [13:0] cnt_sum;
  logic signed [65:0] acc_y;

  logic        out_valid_r;
  logic [12:0] out_miss_r;
  sum_t        out_sum_r;

  assign adv      = !(p4_valid_r && p4_last_r && out_valid_r && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign accum    = in_command == CMD_ACCUM;

  always_comb begin
    miss_item = '0;
    for (int s = 0; s < SLOTS; s++) begin
      miss_item = miss_item + 3'(slot_missing(in_geno_a[2*s +: 2], in_geno_b[2*s +: 2]));
      bank_rd[s] = {in_byte_position[POS_W-1:0],
                    slot_index(in_geno_a[2*s +: 2], in_geno_b[2*s +: 2])};
      bank_wr[s].en   = accept && !accum && (in_table_address[4:3] == 2'(s));
      bank_wr[s].addr = {in_table_address[14:5], in_table_address[2:0]};
      bank_wr[s].data = in_table_value;
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_bank
    gpta_bank u_bank (
      .clk     (clk),
      .wr      (bank_wr[g]),
      .rd_en   (adv),
      .rd_addr (bank_rd[g]),
      .rd_data (bank_data[g])
    );
  end

  // sum update: clamp(acc + c) to the run-independent bounds of this item
  always_comb begin
    acc_y = 66'(acc_r) + 66'(p4_c_r);
    if (acc_y < 66'(p4_lo_r)) begin
      acc_nxt = p4_lo_r;
    end else if (acc_y > 66'(p4_hi_r)) begin
      acc_nxt = p4_hi_r;
    end else begin
      acc_nxt = acc_y[63:0];
    end
    cnt_sum = 14'(cnt_r) + 14'(p4_miss_r);
    cnt_nxt = (cnt_sum > 14'(MISS_MAX)) ? MISS_MAX : cnt_sum[12:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      p4_valid_r  <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv && p4_valid_r && p4_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        p1_valid_r <= accept && accum;
        p2_valid_r <= p1_valid_r;
        p3_valid_r <= p2_valid_r;
        p4_valid_r <= p3_valid_r;
        if (p4_valid_r) begin
          if (p4_last_r) begin
            acc_r <= '0;
            cnt_r <= '0;
          end else begin
            acc_r <= acc_nxt;
            cnt_r <= cnt_nxt;
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_last_r <= in_last;
      p1_miss_r <= miss_item;

      // fold slots 0 and 1
      p2_last_r <= p1_last_r;
      p2_miss_r <= p1_miss_r;
      p2_c_r    <= 34'($signed(bank_data[0])) + 34'($signed(bank_data[1]));
      p2_lo_r   <= clamp_add(SUM_MIN, $signed(bank_data[1]));
      p2_hi_r   <= clamp_add(SUM_MAX, $signed(bank_data[1]));
      p2_v2_r   <= $signed(bank_data[2]);
      p2_v3_r   <= $signed(bank_data[3]);

      // slot 2
      p3_last_r <= p2_last_r;
      p3_miss_r <= p2_miss_r;
      p3_c_r    <= p2_c_r + 34'(p2_v2_r);
      p3_lo_r   <= clamp_add(p2_lo_r, p2_v2_r);
      p3_hi_r   <= clamp_add(p2_hi_r, p2_v2_r);
      p3_v3_r   <= p2_v3_r;

      // slot 3
      p4_last_r <= p3_last_r;
      p4_miss_r <= p3_miss_r;
      p4_c_r    <= p3_c_r + 34'(p3_v3_r);
      p4_lo_r   <= clamp_add(p3_lo_r, p3_v3_r);
      p4_hi_r   <= clamp_add(p3_hi_r, p3_v3_r);

      if (p4_valid_r && p4_last_r) begin
        out_sum_r  <= acc_nxt;
        out_miss_r <= cnt_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_missing_count = out_miss_r;
  assign out_sum_value     = out_sum_r;

endmodule

/* rtl/core/gpta_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpta_bank
// One bank of the product table: the 8-word group of a single slot for every
// byte position. One write port, one registered read port.
// ----------------------------------------------------------------------------
module gpta_bank (
  input  logic                  clk,
  input  gpta_pkg::bank_wr_t    wr,
  input  logic                  rd_en,
  input  gpta_pkg::bank_addr_t  rd_addr,
  output gpta_pkg::word_t       rd_data
);
  import gpta_pkg::*;

  word_t mem_r [BANK_DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* verif/tb_genotype_pair_table_accumulate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_genotype_pair_table_accumulate
// Loads product words and streams genotype byte pairs through the table
// accumulator with random idling on both channels. A predictor mirrors the
// table and the running missing count and sum, and every run total that
// comes out is compared with the oldest predicted total.
// ----------------------------------------------------------------------------
module tb_genotype_pair_table_accumulate;
  import gpta_pkg::*;

  localparam int TABLE_WORDS    = POSITIONS * ENTRIES_PER_POSITION;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CALM_TAIL      = 200;

  typedef struct {
    logic               cmd;
    logic [14:0]        addr;
    logic signed [31:0] value;
    logic [7:0]         geno_a;
    logic [7:0]         geno_b;
    logic [POS_W-1:0]   pos;
    logic               last;
    bit                 drain_first;
  } table_op_t;

  typedef struct {
    logic [MISS_W-1:0]  missing;
    logic signed [63:0] sum;
  } run_total_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic [14:0]        in_table_address;
  logic signed [31:0] in_table_value;
  logic [7:0]         in_geno_a;
  logic [7:0]         in_geno_b;
  logic [9:0]         in_byte_position;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  logic [12:0]        out_missing_count;
  logic signed [63:0] out_sum_value;

  genotype_pair_table_accumulate dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_table_address  (in_table_address),
    .in_table_value    (in_table_value),
    .in_geno_a         (in_geno_a),
    .in_geno_b         (in_geno_b),
    .in_byte_position  (in_byte_position),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_missing_count (out_missing_count),
    .out_sum_value     (out_sum_value)
  );

  // stimulus side
  table_op_t          table_ops[$];
  bit                 word_loaded [0:TABLE_WORDS-1];
  logic [POS_W-1:0]   work_pos [0:11];
  bit                 drain_next;

  // predictor side
  logic [31:0]        product_words [0:TABLE_WORDS-1];
  logic [MISS_W-1:0]  missing_so_far;
  logic signed [63:0] sum_so_far;
  run_total_t         run_totals_due[$];

  table_op_t          offered;
  run_total_t         due;
  int                 send_gap;
  int                 stall_left;
  int                 hold_left;
  bit                 held_off;
  bit                 calm;
  int                 ops_taken;
  int                 mismatches;
  int                 cycle_count;
  int                 quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Entry within the slot's 8-word group
  function automatic logic [2:0] pair_entry(input logic [1:0] a, input logic [1:0] b);
    logic miss;
    miss = (a == 2'd3) || (b == 2'd3);
    return {a[1] | b[1], (a[1] & b[1]) | (a[0] & b[0]) | miss, a[0] | b[0]};
  endfunction

  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3: return $urandom_range(0, 131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_geno();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'hAA;
      3: return 8'h55;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 6) == 0) begin
      return POS_W'($urandom);
    end
    return work_pos[$urandom_range(0, 11)];
  endfunction

  task automatic push_op(input table_op_t op);
    op.drain_first = drain_next;
    drain_next = 1'b0;
    table_ops.push_back(op);
  endtask

  task automatic queue_load(input logic [14:0] addr, input logic signed [31:0] value);
    table_op_t op;
    op.cmd    = CMD_LOAD;
    op.addr   = addr;
    op.value  = value;
    op.geno_a = 8'($urandom);
    op.geno_b = 8'($urandom);
    op.pos    = POS_W'($urandom);
    op.last   = 1'($urandom_range(0, 1));
    word_loaded[addr] = 1'b1;
    push_op(op);
  endtask

  // Loads any word the pair would read that has never been written, so no
  // undefined table entry is ever looked up.
  task automatic queue_pair(input logic [7:0] ga, input logic [7:0] gb,
                            input logic [POS_W-1:0] pos, input logic last);
    table_op_t   op;
    logic [14:0] word;
    for (int s = 0; s < SLOTS; s++) begin
      word = {pos, 2'(s), pair_entry(ga[2*s +: 2], gb[2*s +: 2])};
      if (!word_loaded[word]) begin
        queue_load(word, pick_q16());
      end
    end
    op.cmd    = CMD_ACCUM;
    op.addr   = 15'($urandom);
    op.value  = $urandom;
    op.geno_a = ga;
    op.geno_b = gb;
    op.pos    = pos;
    op.last   = last;
    push_op(op);
  endtask

  task automatic queue_random_traffic(input int count);
    int stop;
    int run_len;
    stop = table_ops.size() + count;
    drain_next = 1'b1;
    while (table_ops.size() < stop) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_load(15'($urandom), pick_q16());
        end else begin
          queue_load({work_pos[$urandom_range(0, 11)], 5'($urandom)}, pick_q16());
        end
      end else begin
        run_len = $urandom_range(1, 10);
        for (int k = 0; k < run_len; k++) begin
          queue_pair(pick_geno(), pick_geno(), pick_pos(), k == run_len - 1);
        end
      end
    end
  endtask

  // Predictor: one accepted transaction on the input channel
  task automatic apply_op(input table_op_t op);
    logic [1:0]         a;
    logic [1:0]         b;
    logic [14:0]        word;
    logic signed [64:0] wide;
    run_total_t         total;
    if (op.cmd == CMD_LOAD) begin
      product_words[op.addr] = op.value;
    end else begin
      for (int s = 0; s < SLOTS; s++) begin
        a = op.geno_a[2*s +: 2];
        b = op.geno_b[2*s +: 2];
        word = {op.pos, 2'(s), pair_entry(a, b)};
        if ((a == 2'd3 || b == 2'd3) && missing_so_far != MISS_MAX) begin
          missing_so_far = missing_so_far + 1'b1;
        end
        wide = {sum_so_far[63], sum_so_far}
             + {{33{product_words[word][31]}}, product_words[word]};
        if (wide[64] != wide[63]) begin
          sum_so_far = wide[64] ? SUM_MIN : SUM_MAX;
        end else begin
          sum_so_far = wide[63:0];
        end
      end
      if (op.last) begin
        total.missing = missing_so_far;
        total.sum     = sum_so_far;
        run_totals_due.push_back(total);
        missing_so_far = '0;
        sum_so_far     = '0;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_LOAD;
    in_table_address = '0;
    in_table_value   = '0;
    in_geno_a        = '0;
    in_geno_b        = '0;
    in_byte_position = '0;
    in_last          = 1'b0;
    out_stall        = 1'b0;
    missing_so_far   = '0;
    sum_so_far       = '0;
    send_gap         = 0;
    stall_left       = 0;
    hold_left        = 0;
    held_off         = 1'b0;
    calm             = 1'b0;
    ops_taken        = 0;
    mismatches       = 0;
    cycle_count      = 0;
    quiet_cycles     = 0;
    drain_next       = 1'b0;
    for (int i = 0; i < 11; i++) begin
      work_pos[i] = POS_W'($urandom);
    end
    work_pos[11] = '1;

    // directed: table address and position extremes, all-zero codes,
    // all missing, alternating codes across and within a run, mixed codes
    queue_load(15'h0000, 32'sh7FFF_FFFF);
    queue_load(15'h7FFF, 32'sh8000_0000);
    queue_pair(8'h00, 8'h00, 10'd0, 1'b1);
    queue_pair(8'hFF, 8'hFF, 10'd1023, 1'b1);
    queue_pair(8'hAA, 8'h55, 10'd5, 1'b0);
    queue_pair(8'h55, 8'hAA, 10'd5, 1'b1);
    queue_pair(8'hE4, 8'h1B, 10'd7, 1'b1);

    queue_random_traffic(275);
    // one long run of missing slots to take the count to 4096, short of its 8191 top
    for (int k = 0; k < 1024; k++) begin
      queue_pair(8'hFF, pick_geno(), work_pos[k % 12], k == 1023);
    end
    queue_random_traffic(275);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (table_ops.size() != 0 || in_valid) @(posedge clk);
    while (run_totals_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_op(offered);
        ops_taken <= ops_taken + 1;
      end
      calm <= table_ops.size() < CALM_TAIL;
      if (!in_valid || !in_stall) begin
        if (table_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else if (table_ops[0].drain_first && run_totals_due.size() != 0) begin
          in_valid <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (table_ops.size() >= CALM_TAIL && (cycle_count >> 8) % 3 != 0
                     && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          offered = table_ops.pop_front();
          in_command       <= offered.cmd;
          in_table_address <= offered.addr;
          in_table_value   <= offered.value;
          in_geno_a        <= offered.geno_a;
          in_geno_b        <= offered.geno_b;
          in_byte_position <= offered.pos;
          in_last          <= offered.last;
          in_valid         <= 1'b1;
        end
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (run_totals_due.size() == 0) begin
          $error("unexpected run total: missing_count %0d, sum_value %0d",
                 out_missing_count, out_sum_value);
          mismatches++;
        end else begin
          due = run_totals_due.pop_front();
          if (out_missing_count !== due.missing) begin
            $error("missing_count: expected %0d, actual %0d", due.missing, out_missing_count);
            mismatches++;
          end
          if (out_sum_value !== due.sum) begin
            $error("sum_value: expected %0d, actual %0d", due.sum, out_sum_value);
            mismatches++;
          end
        end
      end
      // long hold-off while the sender keeps going, to back the pipe up
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (!held_off && ops_taken >= 250) begin
        held_off  = 1'b1;
        hold_left = 299;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm && (cycle_count >> 7) % 3 != 1 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
